@@ rtl/h2r_pkg.sv @@
// Shared constants and types for the HSV to RGB 3-3-2 pixel converter.
package h2r_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ONE       = 1 << FRAC_BITS;

    // Fixed field widths of the ports
    localparam int HUE_W   = 9;
    localparam int IN_W    = 9;
    localparam int COLOR_W = 8;

    // Hue sector arithmetic
    localparam int SECT_DEG = 60;
    localparam int WT_W     = 6;                     // holds 0..60

    // inner = s*w + 60*(ONE - s) <= 60*ONE
    localparam int INNER_W  = FRAC_BITS + 6;
    localparam int NUM_W    = INNER_W + IN_W;
    localparam int SCALE_W  = 3;
    localparam int SCALED_W = NUM_W + SCALE_W;

    // t = floor(num*k / ONE^2) stays <= 7*60
    localparam int T_W      = 9;
    localparam int Q_W      = 3;

    // floor(t/60) as (t*RECIP) >> RECIP_SH, exact for t <= 420
    localparam int RECIP    = 1093;
    localparam int RECIP_W  = 11;
    localparam int RECIP_SH = 16;
    localparam int QPROD_W  = T_W + RECIP_W;

    localparam logic [SCALE_W-1:0] SCALE_RG = 3'd7;
    localparam logic [SCALE_W-1:0] SCALE_B  = 3'd3;

    typedef enum logic [2:0] {
        SECT_0,
        SECT_1,
        SECT_2,
        SECT_3,
        SECT_4,
        SECT_5,
        SECT_GREY
    } sector_t;

endpackage

@@ rtl/hsv_to_rgb332.sv @@
// HSV to RGB 3-3-2 converter, top level with the hue sector stages.
// One pixel word in and one packed pixel out per clock while the output is not
// stalled, through five register stages: sector decode, channel weights, value
// multiply, depth scale, and divide by 60. Saturation and value
// above 1.0 are clamped; a hue of 360 or more yields a grey level. The whole
// pipeline advances together, so it holds only while the output word waits.
module hsv_to_rgb332 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [h2r_pkg::HUE_W-1:0]     s_hue_deg,
    input  logic [h2r_pkg::IN_W-1:0]      s_saturation,
    input  logic [h2r_pkg::IN_W-1:0]      s_brightness,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [h2r_pkg::COLOR_W-1:0]   m_color_332
);

    logic en;

    // stage 1
    logic                            vld1_reg;
    logic [h2r_pkg::IN_W-1:0]        sat1_reg, sat1_next;
    logic [h2r_pkg::IN_W-1:0]        val1_reg, val1_next;
    h2r_pkg::sector_t                sect1_reg, sect1_next;
    logic [h2r_pkg::WT_W-1:0]        frac1_reg, frac1_next;
    logic [h2r_pkg::HUE_W-1:0]       hue_off;

    // stage 2
    logic                            vld2_reg;
    logic [h2r_pkg::IN_W-1:0]        val2_reg;
    logic [h2r_pkg::INNER_W-1:0]     inr_reg, inr_next;
    logic [h2r_pkg::INNER_W-1:0]     ing_reg, ing_next;
    logic [h2r_pkg::INNER_W-1:0]     inb_reg, inb_next;
    logic [h2r_pkg::WT_W-1:0]        wx, wr, wg, wb;
    logic [h2r_pkg::INNER_W-1:0]     base;

    // stages 3..5 valid
    logic vld3_reg, vld4_reg, vld5_reg;

    logic [h2r_pkg::Q_W-1:0] lvl_r, lvl_g, lvl_b;

    assign en      = !vld5_reg || m_ready;
    assign s_ready = en;
    assign m_valid = vld5_reg;

    // Stage 1: clamp and sector decode
    always_comb begin
        sat1_next = (32'(s_saturation) > h2r_pkg::ONE) ?
                    h2r_pkg::IN_W'(h2r_pkg::ONE) : s_saturation;
        val1_next = (32'(s_brightness) > h2r_pkg::ONE) ?
                    h2r_pkg::IN_W'(h2r_pkg::ONE) : s_brightness;
        if (s_hue_deg < 9'd60) begin
            sect1_next = h2r_pkg::SECT_0;
            hue_off    = 9'd0;
        end else if (s_hue_deg < 9'd120) begin
            sect1_next = h2r_pkg::SECT_1;
            hue_off    = 9'd60;
        end else if (s_hue_deg < 9'd180) begin
            sect1_next = h2r_pkg::SECT_2;
            hue_off    = 9'd120;
        end else if (s_hue_deg < 9'd240) begin
            sect1_next = h2r_pkg::SECT_3;
            hue_off    = 9'd180;
        end else if (s_hue_deg < 9'd300) begin
            sect1_next = h2r_pkg::SECT_4;
            hue_off    = 9'd240;
        end else if (s_hue_deg < 9'd360) begin
            sect1_next = h2r_pkg::SECT_5;
            hue_off    = 9'd300;
        end else begin
            sect1_next = h2r_pkg::SECT_GREY;
            hue_off    = s_hue_deg;
        end
        frac1_next = h2r_pkg::WT_W'(s_hue_deg - hue_off);
    end

    // Stage 2: per-channel weight (60, ramp or 0) folded with the offset term
    always_comb begin
        wx = frac1_reg;
        wr = '0;
        wg = '0;
        wb = '0;
        case (sect1_reg)
            h2r_pkg::SECT_0: begin
                wr = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG);
                wg = wx;
            end
            h2r_pkg::SECT_1: begin
                wx = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG) - frac1_reg;
                wr = wx;
                wg = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG);
            end
            h2r_pkg::SECT_2: begin
                wg = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG);
                wb = wx;
            end
            h2r_pkg::SECT_3: begin
                wx = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG) - frac1_reg;
                wg = wx;
                wb = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG);
            end
            h2r_pkg::SECT_4: begin
                wr = wx;
                wb = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG);
            end
            h2r_pkg::SECT_5: begin
                wx = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG) - frac1_reg;
                wr = h2r_pkg::WT_W'(h2r_pkg::SECT_DEG);
                wb = wx;
            end
            default: begin
                wx = '0;
            end
        endcase
        // offset share: 60*(ONE - s)
        base = h2r_pkg::INNER_W'(h2r_pkg::SECT_DEG) *
               (h2r_pkg::INNER_W'(h2r_pkg::ONE) - h2r_pkg::INNER_W'(sat1_reg));
        inr_next = h2r_pkg::INNER_W'(sat1_reg) * h2r_pkg::INNER_W'(wr) + base;
        ing_next = h2r_pkg::INNER_W'(sat1_reg) * h2r_pkg::INNER_W'(wg) + base;
        inb_next = h2r_pkg::INNER_W'(sat1_reg) * h2r_pkg::INNER_W'(wb) + base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= s_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat1_reg  <= sat1_next;
            val1_reg  <= val1_next;
            sect1_reg <= sect1_next;
            frac1_reg <= frac1_next;
            val2_reg  <= val1_reg;
            inr_reg   <= inr_next;
            ing_reg   <= ing_next;
            inb_reg   <= inb_next;
        end
    end

    h2r_chan u_chan_r (
        .aclk  (aclk),
        .en    (en),
        .val   (val2_reg),
        .inner (inr_reg),
        .scale (h2r_pkg::SCALE_RG),
        .level (lvl_r)
    );

    h2r_chan u_chan_g (
        .aclk  (aclk),
        .en    (en),
        .val   (val2_reg),
        .inner (ing_reg),
        .scale (h2r_pkg::SCALE_RG),
        .level (lvl_g)
    );

    h2r_chan u_chan_b (
        .aclk  (aclk),
        .en    (en),
        .val   (val2_reg),
        .inner (inb_reg),
        .scale (h2r_pkg::SCALE_B),
        .level (lvl_b)
    );

    assign m_color_332 = {lvl_r, lvl_g, lvl_b[1:0]};

endmodule

@@ rtl/h2r_chan.sv @@
// One color channel: scale by value, by channel depth, then divide by 60.
module h2r_chan (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [h2r_pkg::IN_W-1:0]      val,
    input  logic [h2r_pkg::INNER_W-1:0]   inner,
    input  logic [h2r_pkg::SCALE_W-1:0]   scale,
    output logic [h2r_pkg::Q_W-1:0]       level
);

    logic [h2r_pkg::NUM_W-1:0]    num_reg,  num_next;
    logic [h2r_pkg::T_W-1:0]      t_reg,    t_next;
    logic [h2r_pkg::Q_W-1:0]      q_reg,    q_next;
    logic [h2r_pkg::SCALED_W-1:0] scaled;
    logic [h2r_pkg::QPROD_W-1:0]  qprod;

    always_comb begin
        num_next = h2r_pkg::NUM_W'(val) * h2r_pkg::NUM_W'(inner);
        scaled   = h2r_pkg::SCALED_W'(num_reg) * h2r_pkg::SCALED_W'(scale);
        t_next   = scaled[2*h2r_pkg::FRAC_BITS +: h2r_pkg::T_W];
        qprod    = h2r_pkg::QPROD_W'(t_reg) * h2r_pkg::QPROD_W'(h2r_pkg::RECIP);
        q_next   = qprod[h2r_pkg::RECIP_SH +: h2r_pkg::Q_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            t_reg   <= t_next;
            q_reg   <= q_next;
        end
    end

    assign level = q_reg;

endmodule

@@ rtl/h2r_chk.sv @@
// Port-level checks for the HSV to RGB 3-3-2 converter, with its bind.
module h2r_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [h2r_pkg::COLOR_W-1:0]   m_color_332
);

    // A word waiting at the output keeps its valid.
    a_out_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output word dropped while stalled");

    // A word waiting at the output keeps its pixel.
    a_out_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_color_332))
        else $error("output pixel changed while stalled");

    // Input is taken exactly when the output side can move.
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output flow");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind hsv_to_rgb332 h2r_chk u_h2r_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_color_332 (m_color_332)
);

@@ verif/hsv_to_rgb332_test.sv @@
// Self-checking testbench for the HSV to RGB 3-3-2 pixel converter.
`timescale 1ns / 1ps

module hsv_to_rgb332_test;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [h2r_pkg::HUE_W-1:0]       s_hue_deg = '0;
    logic [h2r_pkg::IN_W-1:0]        s_saturation = '0;
    logic [h2r_pkg::IN_W-1:0]        s_brightness = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [h2r_pkg::COLOR_W-1:0]     m_color_332;

    logic [h2r_pkg::COLOR_W-1:0]     pending_colors[$];
    int                              error_count = 0;
    bit                              tx_idle_en = 1'b1;
    bit                              rx_idle_en = 1'b1;
    int                              ready_hold = 0;

    hsv_to_rgb332 uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue_deg    (s_hue_deg),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_color_332  (m_color_332)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Exact conversion: every component is a numerator over ONE*ONE*60.
    function automatic logic [h2r_pkg::COLOR_W-1:0] predict_color(
            logic [h2r_pkg::HUE_W-1:0] hue,
            logic [h2r_pkg::IN_W-1:0] sat_in,
            logic [h2r_pkg::IN_W-1:0] val_in);
        longint unsigned one_fx, sixty, h, s, v, denom, c_num, m_num, x_num, hm, hue_dist;
        longint unsigned rp, gp, bp, r, g, b;
        h2r_pkg::sector_t sect;
        one_fx = 64'(h2r_pkg::ONE);
        sixty = 64'(h2r_pkg::SECT_DEG);
        h = 64'(hue);
        s = 64'(sat_in);
        v = 64'(val_in);
        if (s > one_fx) s = one_fx;
        if (v > one_fx) v = one_fx;
        denom = one_fx * one_fx * sixty;
        c_num = v * s * sixty;
        m_num = v * one_fx * sixty - c_num;
        hm = h % (64'd2 * sixty);
        hue_dist = (hm >= sixty) ? (hm - sixty) : (sixty - hm);
        x_num = v * s * (sixty - hue_dist);
        sect = (h >= 64'd6 * sixty) ? h2r_pkg::SECT_GREY
                                    : h2r_pkg::sector_t'(3'(h / sixty));
        rp = 0;
        gp = 0;
        bp = 0;
        case (sect)
            h2r_pkg::SECT_0: begin rp = c_num; gp = x_num; end
            h2r_pkg::SECT_1: begin rp = x_num; gp = c_num; end
            h2r_pkg::SECT_2: begin gp = c_num; bp = x_num; end
            h2r_pkg::SECT_3: begin gp = x_num; bp = c_num; end
            h2r_pkg::SECT_4: begin rp = x_num; bp = c_num; end
            h2r_pkg::SECT_5: begin rp = c_num; bp = x_num; end
            default: ;
        endcase
        r = ((rp + m_num) * 64'(h2r_pkg::SCALE_RG)) / denom;
        g = ((gp + m_num) * 64'(h2r_pkg::SCALE_RG)) / denom;
        b = ((bp + m_num) * 64'(h2r_pkg::SCALE_B)) / denom;
        return {r[2:0], g[2:0], b[1:0]};
    endfunction

    task automatic report_mismatch(string what, logic [h2r_pkg::COLOR_W-1:0] exp_val,
                                   logic [h2r_pkg::COLOR_W-1:0] got_val);
        $display("MISMATCH %s: expected 0x%02h got 0x%02h at %0t", what, exp_val, got_val,
                 $realtime);
        error_count++;
    endtask

    // Drive one pixel word at the falling edge and hold it until accepted.
    task automatic send_pixel(logic [h2r_pkg::HUE_W-1:0] hue,
                              logic [h2r_pkg::IN_W-1:0] sat_in,
                              logic [h2r_pkg::IN_W-1:0] val_in);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_hue_deg    <= hue;
        s_saturation <= sat_in;
        s_brightness <= val_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_colors.push_back(predict_color(hue, sat_in, val_in));
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Receiver stalls in random bursts while receive idling is enabled.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else if (rx_idle_en && aresetn && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            ready_hold = $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_colors.size() == 0) begin
                report_mismatch("unexpected word", '0, m_color_332);
            end else begin
                logic [h2r_pkg::COLOR_W-1:0] want;
                want = pending_colors.pop_front();
                if (m_color_332 !== want)
                    report_mismatch("color_332", want, m_color_332);
            end
        end
    end

    task automatic test_sector_edges();
        int edges[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
        foreach (edges[i])
            send_pixel(h2r_pkg::HUE_W'(edges[i]), h2r_pkg::IN_W'(h2r_pkg::ONE),
                       h2r_pkg::IN_W'(h2r_pkg::ONE));
        drop_valid();
    endtask

    task automatic test_special_cases();
        send_pixel(9'd360, 9'd128, 9'd200);                    // grey: offset only
        send_pixel(9'd511, 9'd511, 9'd511);                    // grey with both clamps
        send_pixel(9'd45, 9'd257, 9'd300);                     // clamp just above one
        send_pixel(9'd200, h2r_pkg::IN_W'(h2r_pkg::ONE), 9'd0); // black
        send_pixel(9'd100, 9'd0, h2r_pkg::IN_W'(h2r_pkg::ONE)); // white
        send_pixel(9'd30, 9'd511, 9'd0);
        drop_valid();
    endtask

    task automatic send_random_pixel();
        logic [h2r_pkg::HUE_W-1:0] hue;
        logic [h2r_pkg::IN_W-1:0]  sat_in;
        logic [h2r_pkg::IN_W-1:0]  val_in;
        hue    = h2r_pkg::HUE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(360, 511)
                                                             : $urandom_range(0, 359));
        sat_in = h2r_pkg::IN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, h2r_pkg::ONE));
        val_in = h2r_pkg::IN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, h2r_pkg::ONE));
        send_pixel(hue, sat_in, val_in);
    endtask

    task automatic test_random();
        repeat (880) send_random_pixel();
        drop_valid();
    endtask

    // Last part: full rate, no idling on either side.
    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        wait (ready_hold == 0);
        repeat (150) send_random_pixel();
        drop_valid();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_sector_edges();
        test_special_cases();
        test_random();
        test_back_to_back();
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
